### src/cqu_pkg.sv
// shared types and constants for the circular queue with unique enqueue
// no dependencies; compile first
package cqu_pkg;

   // field widths fixed by the item format
   localparam int ACTION_W = 2;
   localparam int VALUE_W  = 8;
   localparam int LEVEL_W  = 4;

   // default queue depth
   localparam int DEPTH_DEFAULT = 8;

   // marker bytes for empty peeks and empty dequeues
   localparam logic [VALUE_W-1:0] EMPTY_MARK = 8'd35;
   localparam logic [VALUE_W-1:0] EMPTY_DEQ  = 8'd32;

   // request actions
   typedef enum logic [ACTION_W-1:0] {
      ACT_ENQ        = 2'd0,
      ACT_ENQ_UNIQUE = 2'd1,
      ACT_DEQ        = 2'd2,
      ACT_COUNT      = 2'd3
   } action_type;

   // sequencer states
   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_UPDATE = 5'b00100,
      S_FETCH  = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

endpackage

### src/cqu_channels.sv
// valid/ready channel interfaces for request and response items
// depends on cqu_pkg for field widths
interface cqu_req_if;
   logic                         valid;
   logic                         ready;
   logic [cqu_pkg::ACTION_W-1:0] action;
   logic [cqu_pkg::VALUE_W-1:0]  value;

   modport source (output valid, action, value, input ready);
   modport sink   (input valid, action, value, output ready);
endinterface

interface cqu_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [cqu_pkg::VALUE_W-1:0] out_value;
   logic                        accepted;
   logic [cqu_pkg::LEVEL_W-1:0] match_count;
   logic [cqu_pkg::LEVEL_W-1:0] fill_level;
   logic                        is_empty;
   logic                        is_full;
   logic [cqu_pkg::VALUE_W-1:0] front_value;
   logic [cqu_pkg::VALUE_W-1:0] back_value;

   modport source (output valid, out_value, accepted, match_count, fill_level, is_empty,
                   is_full, front_value, back_value, input ready);
   modport sink   (input valid, out_value, accepted, match_count, fill_level, is_empty,
                   is_full, front_value, back_value, output ready);
endinterface

### src/cqu_slot_ram.sv
// slot store: one write port, one read port with registered read data
// depends on cqu_pkg for the element width
module cqu_slot_ram #(
   parameter int DEPTH = cqu_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  logic [cqu_pkg::VALUE_W-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [cqu_pkg::VALUE_W-1:0] rd_data
);

   logic [cqu_pkg::VALUE_W-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

### src/circular_queue_unique_enqueue.sv
// circular byte queue with plain and unique enqueue, dequeue and match count
// depends on cqu_pkg, cqu_channels (interfaces) and cqu_slot_ram
//
//   channel    direction  handshake     contents
//   req_chan   in         valid/ready   action, value
//   rsp_chan   out        valid/ready   out_value, accepted, match_count, fill_level,
//                                       is_empty, is_full, front_value, back_value
//
// the match count reads the held slots one per cycle through the single read port of the
// slot store; a dequeue that leaves entries behind adds a fetch of the new head element.
// reset is synchronous and empties the queue; slot contents are not cleared.
// a finished response waits in the output register while the next request is taken;
// only the final step of that request waits for the response to be taken.
module circular_queue_unique_enqueue #(
   parameter int DEPTH = cqu_pkg::DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   cqu_req_if.sink   req_chan,
   cqu_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // wrapping increment of a slot index
   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
      logic [IDX_W-1:0] r;
      if (a == IDX_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = a + 1'b1;
      end
      return r;
   endfunction

   // control state
   cqu_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]   front_ff, front_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // per-request working registers
   cqu_pkg::action_type         action_ff, action_in;
   logic [cqu_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]            match_ff, match_in;
   logic [CNT_W-1:0]            scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]            scan_addr_ff, scan_addr_in;
   logic [cqu_pkg::VALUE_W-1:0] out_val_ff, out_val_in;
   logic                        acc_ff, acc_in;

   // cached head and tail elements
   logic [cqu_pkg::VALUE_W-1:0] front_val_ff, front_val_in;
   logic [cqu_pkg::VALUE_W-1:0] back_val_ff, back_val_in;

   // response register
   logic [cqu_pkg::VALUE_W-1:0] rsp_out_value_ff;
   logic                        rsp_accepted_ff;
   logic [cqu_pkg::LEVEL_W-1:0] rsp_match_count_ff;
   logic [cqu_pkg::LEVEL_W-1:0] rsp_fill_level_ff;
   logic                        rsp_is_empty_ff;
   logic                        rsp_is_full_ff;
   logic [cqu_pkg::VALUE_W-1:0] rsp_front_value_ff;
   logic [cqu_pkg::VALUE_W-1:0] rsp_back_value_ff;
   logic                        rsp_load;

   // slot store ports
   logic                        ram_we;
   logic [IDX_W-1:0]            ram_waddr;
   logic [cqu_pkg::VALUE_W-1:0] ram_wdata;
   logic [IDX_W-1:0]            ram_raddr;
   logic [cqu_pkg::VALUE_W-1:0] ram_rdata;

   logic                        req_fire;
   logic                        is_full_now;
   logic                        do_push;
   logic [CNT_W-1:0]            scan_next;

   cqu_slot_ram #(.DEPTH(DEPTH)) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_chan.ready = (state_ff == cqu_pkg::S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign is_full_now    = (count_ff == CNT_W'(DEPTH));
   assign scan_next      = scan_idx_ff + 1'b1;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      action_in    = action_ff;
      value_in     = value_ff;
      match_in     = match_ff;
      scan_idx_in  = scan_idx_ff;
      scan_addr_in = scan_addr_ff;
      out_val_in   = out_val_ff;
      acc_in       = acc_ff;
      front_val_in = front_val_ff;
      back_val_in  = back_val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_load     = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = tail_ff;
      ram_wdata    = value_ff;
      ram_raddr    = front_ff;
      do_push      = 1'b0;

      case (state_ff)
         cqu_pkg::S_IDLE: begin
            // take a request and start reading from the head slot
            if (req_fire) begin
               action_in    = cqu_pkg::action_type'(req_chan.action);
               value_in     = req_chan.value;
               match_in     = '0;
               scan_idx_in  = '0;
               scan_addr_in = wrap_inc(front_ff);
               if (count_ff == '0) begin
                  state_in = cqu_pkg::S_UPDATE;
               end else begin
                  state_in = cqu_pkg::S_SCAN;
               end
            end
         end

         cqu_pkg::S_SCAN: begin
            // compare one held slot per cycle, read the next one
            match_in = match_ff + CNT_W'(ram_rdata == value_ff);
            if (scan_next < count_ff) begin
               ram_raddr    = scan_addr_ff;
               scan_addr_in = wrap_inc(scan_addr_ff);
               scan_idx_in  = scan_next;
            end else begin
               state_in = cqu_pkg::S_UPDATE;
            end
         end

         cqu_pkg::S_UPDATE: begin
            out_val_in = '0;
            acc_in     = 1'b0;
            state_in   = cqu_pkg::S_DONE;
            case (action_ff)
               cqu_pkg::ACT_ENQ: begin
                  do_push = !is_full_now;
               end
               cqu_pkg::ACT_ENQ_UNIQUE: begin
                  do_push = !is_full_now && (match_ff == '0);
               end
               cqu_pkg::ACT_DEQ: begin
                  if (count_ff != '0) begin
                     out_val_in = front_val_ff;
                     acc_in     = 1'b1;
                     count_in   = count_ff - 1'b1;
                     if (count_ff == CNT_W'(1)) begin
                        front_in = '0;
                        tail_in  = '0;
                     end else begin
                        // fetch the new head element
                        front_in  = wrap_inc(front_ff);
                        ram_raddr = wrap_inc(front_ff);
                        state_in  = cqu_pkg::S_FETCH;
                     end
                  end else begin
                     out_val_in = cqu_pkg::EMPTY_DEQ;
                  end
               end
               default: begin
               end
            endcase
            // write at the tail slot
            if (do_push) begin
               ram_we      = 1'b1;
               tail_in     = wrap_inc(tail_ff);
               count_in    = count_ff + 1'b1;
               back_val_in = value_ff;
               acc_in      = 1'b1;
               if (count_ff == '0) begin
                  front_val_in = value_ff;
               end
            end
         end

         cqu_pkg::S_FETCH: begin
            front_val_in = ram_rdata;
            state_in     = cqu_pkg::S_DONE;
         end

         cqu_pkg::S_DONE: begin
            // hand over once the response register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = cqu_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = cqu_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cqu_pkg::S_IDLE;
         front_ff     <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      action_ff    <= action_in;
      value_ff     <= value_in;
      match_ff     <= match_in;
      scan_idx_ff  <= scan_idx_in;
      scan_addr_ff <= scan_addr_in;
      out_val_ff   <= out_val_in;
      acc_ff       <= acc_in;
      front_val_ff <= front_val_in;
      back_val_ff  <= back_val_in;
      if (rsp_load) begin
         rsp_out_value_ff   <= out_val_ff;
         rsp_accepted_ff    <= acc_ff;
         rsp_match_count_ff <= cqu_pkg::LEVEL_W'(match_ff);
         rsp_fill_level_ff  <= cqu_pkg::LEVEL_W'(count_ff);
         rsp_is_empty_ff    <= (count_ff == '0);
         rsp_is_full_ff     <= is_full_now;
         rsp_front_value_ff <= (count_ff == '0) ? cqu_pkg::EMPTY_MARK : front_val_ff;
         rsp_back_value_ff  <= (count_ff == '0) ? cqu_pkg::EMPTY_MARK : back_val_ff;
      end
   end

   // response outputs
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_value   = rsp_out_value_ff;
   assign rsp_chan.accepted    = rsp_accepted_ff;
   assign rsp_chan.match_count = rsp_match_count_ff;
   assign rsp_chan.fill_level  = rsp_fill_level_ff;
   assign rsp_chan.is_empty    = rsp_is_empty_ff;
   assign rsp_chan.is_full     = rsp_is_full_ff;
   assign rsp_chan.front_value = rsp_front_value_ff;
   assign rsp_chan.back_value  = rsp_back_value_ff;

`ifndef SYNTH
   // fill level never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill level above depth");

   // an empty queue has both pointers back at slot zero
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (front_ff == '0) && (tail_ff == '0))
      else $error("pointers not rewound on empty queue");

   // a taken request goes straight to scanning or updating
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == cqu_pkg::S_SCAN) || (state_ff == cqu_pkg::S_UPDATE))
      else $error("request not started");

   // matches never outnumber the slots compared so far
   a_match_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cqu_pkg::S_SCAN) |-> (match_ff <= scan_idx_ff))
      else $error("match count ahead of scan");

   // an empty response shows the empty markers
   a_empty_marks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_is_empty_ff) |->
         (rsp_front_value_ff == cqu_pkg::EMPTY_MARK) &&
         (rsp_back_value_ff == cqu_pkg::EMPTY_MARK) && (rsp_fill_level_ff == '0))
      else $error("empty response without markers");
`endif

endmodule

### bench/cqu_response_checker.sv
// response checker for the circular queue with unique enqueue
// watches both channels, keeps its own copy of the queue and compares every response
// depends on cqu_pkg and the cqu_req_if / cqu_rsp_if interfaces
module cqu_response_checker #(
   parameter int DEPTH = cqu_pkg::DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   cqu_req_if   req_chan,
   cqu_rsp_if   rsp_chan,
   output int   mismatch_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [cqu_pkg::VALUE_W-1:0] out_value;
      logic                        accepted;
      logic [cqu_pkg::LEVEL_W-1:0] match_count;
      logic [cqu_pkg::LEVEL_W-1:0] fill_level;
      logic                        is_empty;
      logic                        is_full;
      logic [cqu_pkg::VALUE_W-1:0] front_value;
      logic [cqu_pkg::VALUE_W-1:0] back_value;
   } queue_response_type;

   // own copy of the queue contents
   logic [cqu_pkg::VALUE_W-1:0] slots [DEPTH];
   int                          head_idx = 0;
   int                          held = 0;

   queue_response_type          awaited_responses [$];
   int                          error_tally = 0;

   // carry out one request on the local queue and work out its response
   task automatic apply_queue_action(input cqu_pkg::action_type act,
                                     input logic [cqu_pkg::VALUE_W-1:0] val,
                                     output queue_response_type rsp);
      int hit_count;
      hit_count = 0;
      for (int i = 0; i < held; i++)
         if (slots[(head_idx + i) % DEPTH] == val)
            hit_count++;

      rsp.out_value   = '0;
      rsp.accepted    = 1'b0;
      rsp.match_count = cqu_pkg::LEVEL_W'(hit_count);

      case (act)
         cqu_pkg::ACT_ENQ, cqu_pkg::ACT_ENQ_UNIQUE: begin
            // unique enqueue refuses a value already held; both refuse when full
            if (held < DEPTH && (act == cqu_pkg::ACT_ENQ || hit_count == 0)) begin
               slots[(head_idx + held) % DEPTH] = val;
               held++;
               rsp.accepted = 1'b1;
            end
         end
         cqu_pkg::ACT_DEQ: begin
            if (held > 0) begin
               rsp.out_value = slots[head_idx];
               held--;
               // an emptied queue starts again at slot zero
               head_idx = (held == 0) ? 0 : (head_idx + 1) % DEPTH;
               rsp.accepted = 1'b1;
            end else begin
               rsp.out_value = cqu_pkg::EMPTY_DEQ;
            end
         end
         default: ;
      endcase

      rsp.fill_level = cqu_pkg::LEVEL_W'(held);
      rsp.is_empty   = (held == 0);
      rsp.is_full    = (held >= DEPTH);
      if (held == 0) begin
         rsp.front_value = cqu_pkg::EMPTY_MARK;
         rsp.back_value  = cqu_pkg::EMPTY_MARK;
      end else begin
         rsp.front_value = slots[head_idx];
         rsp.back_value  = slots[(head_idx + held - 1) % DEPTH];
      end
   endtask

   task automatic compare_field(input string field_name,
                                input logic [cqu_pkg::VALUE_W-1:0] want,
                                input logic [cqu_pkg::VALUE_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field_name,
                  want, got);
         error_tally++;
      end
   endtask

   // responses are retired before the request of the same edge is added
   always @(posedge clock) begin
      queue_response_type want;
      queue_response_type next_rsp;
      if (reset) begin
         head_idx = 0;
         held     = 0;
         awaited_responses.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_responses.size() == 0) begin
               $display("%0t ns: response with none outstanding, expected nothing, actual %0d",
                        $time, rsp_chan.out_value);
               error_tally++;
            end else begin
               want = awaited_responses.pop_front();
               compare_field("out_value",   want.out_value,   rsp_chan.out_value);
               compare_field("accepted",    want.accepted,    rsp_chan.accepted);
               compare_field("match_count", want.match_count, rsp_chan.match_count);
               compare_field("fill_level",  want.fill_level,  rsp_chan.fill_level);
               compare_field("is_empty",    want.is_empty,    rsp_chan.is_empty);
               compare_field("is_full",     want.is_full,     rsp_chan.is_full);
               compare_field("front_value", want.front_value, rsp_chan.front_value);
               compare_field("back_value",  want.back_value,  rsp_chan.back_value);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            apply_queue_action(cqu_pkg::action_type'(req_chan.action), req_chan.value,
                               next_rsp);
            awaited_responses.push_back(next_rsp);
         end
      end
      mismatch_count <= error_tally;
      pending        <= awaited_responses.size();
   end

endmodule

### bench/circular_queue_unique_enqueue_test.sv
// top of the circular queue test: clock, reset, request stimulus and response back-pressure
// depends on cqu_pkg, the channel interfaces, the block and cqu_response_checker
module circular_queue_unique_enqueue_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH  = cqu_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 1450;
   localparam int STALL_AT     = 400;
   localparam int DRAIN_AT     = 800;
   localparam int QUIET_ITEMS  = 200;
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 500000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic stall_order = 1'b0;
   logic quiet = 1'b0;
   int   failures;
   int   pending;

   cqu_req_if req_chan ();
   cqu_rsp_if rsp_chan ();

   circular_queue_unique_enqueue #(.DEPTH(QUEUE_DEPTH)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   cqu_response_checker #(.DEPTH(QUEUE_DEPTH)) resp_check (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .mismatch_count (failures),
      .pending        (pending)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // offer one request and hold it until it is taken
   task automatic send_request(input cqu_pkg::action_type act,
                               input logic [cqu_pkg::VALUE_W-1:0] val);
      req_chan.valid  <= 1'b1;
      req_chan.action <= act;
      req_chan.value  <= val;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // sender idle, with junk on the payload
   task automatic pause_sender(input int cycles);
      req_chan.valid  <= 1'b0;
      req_chan.action <= cqu_pkg::ACTION_W'($urandom);
      req_chan.value  <= cqu_pkg::VALUE_W'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_with_gap(input cqu_pkg::action_type act,
                                input logic [cqu_pkg::VALUE_W-1:0] val);
      if (!quiet && $urandom_range(0, 9) == 0)
         pause_sender($urandom_range(1, 12));
      send_request(act, val);
   endtask

   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // action mix per phase: filling, draining, even, unique-heavy
   function automatic cqu_pkg::action_type pick_action(input int bias);
      int r;
      r = $urandom_range(0, 99);
      case (bias)
         0:       return (r < 45) ? cqu_pkg::ACT_ENQ : (r < 75) ? cqu_pkg::ACT_ENQ_UNIQUE
                               : (r < 90) ? cqu_pkg::ACT_DEQ : cqu_pkg::ACT_COUNT;
         1:       return (r < 15) ? cqu_pkg::ACT_ENQ : (r < 25) ? cqu_pkg::ACT_ENQ_UNIQUE
                               : (r < 85) ? cqu_pkg::ACT_DEQ : cqu_pkg::ACT_COUNT;
         3:       return (r < 15) ? cqu_pkg::ACT_ENQ : (r < 60) ? cqu_pkg::ACT_ENQ_UNIQUE
                               : (r < 80) ? cqu_pkg::ACT_DEQ : cqu_pkg::ACT_COUNT;
         default: return cqu_pkg::action_type'($urandom_range(0, 3));
      endcase
   endfunction

   // half the values from a narrow pool so that matches and refusals happen
   function automatic logic [cqu_pkg::VALUE_W-1:0] pick_value(
      input logic [cqu_pkg::VALUE_W-1:0] pool_base);
      if ($urandom_range(0, 1))
         return cqu_pkg::VALUE_W'(pool_base + $urandom_range(0, 3));
      return cqu_pkg::VALUE_W'($urandom_range(0, 255));
   endfunction

   // receiver: random hold-off bursts, one long hold when ordered
   initial begin
      int  hold_left;
      logic stall_taken;
      hold_left   = 0;
      stall_taken = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_order && !stall_taken) begin
            stall_taken    <= 1'b1;
            hold_left      <= LONG_HOLD;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left      <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            hold_left      <= $urandom_range(0, 11);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("circular_queue_unique_enqueue_test: FAIL");
      $finish;
   end

   // request stimulus and verdict
   initial begin
      int sent;
      int phase_len;
      int bias;
      logic [cqu_pkg::VALUE_W-1:0] pool_base;

      req_chan.valid  <= 1'b0;
      req_chan.action <= cqu_pkg::ACT_ENQ;
      req_chan.value  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue: dequeue gives a space, count gives zero
      send_with_gap(cqu_pkg::ACT_DEQ, 8'h00);
      send_with_gap(cqu_pkg::ACT_COUNT, 8'h00);
      // extremes, then unique enqueue of a held and of a fresh value
      send_with_gap(cqu_pkg::ACT_ENQ, 8'h00);
      send_with_gap(cqu_pkg::ACT_ENQ, 8'hFF);
      send_with_gap(cqu_pkg::ACT_ENQ_UNIQUE, 8'hFF);
      send_with_gap(cqu_pkg::ACT_ENQ_UNIQUE, 8'h5A);
      // fill up, then both enqueues on a full queue
      for (int i = 0; i < 5; i++)
         send_with_gap(cqu_pkg::ACT_ENQ, (i == 2) ? 8'hAA : 8'hFF);
      send_with_gap(cqu_pkg::ACT_ENQ, 8'h01);
      send_with_gap(cqu_pkg::ACT_ENQ_UNIQUE, 8'h02);
      send_with_gap(cqu_pkg::ACT_COUNT, 8'hFF);
      // move the head on and wrap the tail round the store
      for (int i = 0; i < 5; i++)
         send_with_gap(cqu_pkg::ACT_DEQ, 8'h00);
      send_with_gap(cqu_pkg::ACT_ENQ, 8'h07);
      send_with_gap(cqu_pkg::ACT_ENQ, 8'h07);
      send_with_gap(cqu_pkg::ACT_COUNT, 8'h07);
      // empty it again, one dequeue past empty
      for (int i = 0; i < 6; i++)
         send_with_gap(cqu_pkg::ACT_DEQ, 8'h00);

      // random phases with a bias each
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         phase_len = $urandom_range(8, 48);
         bias      = $urandom_range(0, 3);
         pool_base = cqu_pkg::VALUE_W'($urandom_range(0, 255));
         for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
            if (sent == STALL_AT)
               stall_order <= 1'b1;
            if (sent == DRAIN_AT) begin
               wait_for_drain();
               pause_sender($urandom_range(5, 30));
            end
            if (sent == RANDOM_ITEMS - QUIET_ITEMS)
               quiet <= 1'b1;
            send_with_gap(pick_action(bias), pick_value(pool_base));
            sent++;
         end
      end

      wait_for_drain();
      repeat (4 * (QUEUE_DEPTH + 4)) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("circular_queue_unique_enqueue_test: PASS");
      else
         $display("circular_queue_unique_enqueue_test: FAIL");
      $finish;
   end

endmodule
